### src/nfd_pkg.sv
package nfd_pkg;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code;
        logic [15:0] set_num;
        logic [15:0] rec_num;
        logic [4:0]  chunk;
        logic [63:0] value;
        logic [3:0]  nbytes;
        logic        done;
        logic [2:0]  status;
    } t_item;

    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_TPL    = 2'd1;
    localparam logic [1:0] KIND_FLOW   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_BAD_VER  = 3'd2;
    localparam logic [2:0] ST_BAD_TPL  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [63:0] VER_V5     = 64'd5;
    localparam logic [63:0] VER_V9     = 64'd9;
    localparam logic [4:0]  V5_FIELDS  = 5'd20;
    localparam logic [15:0] TPL_ID_MAX = 16'd255;

    function automatic logic [3:0] v5_hdr_len(input logic [4:0] pos);
        logic [3:0] r;
        unique case (pos)
            5'd0, 5'd1, 5'd8:  r = 4'd2;
            5'd6, 5'd7:        r = 4'd1;
            default:           r = 4'd4;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] v9_hdr_len(input logic [4:0] pos);
        logic [3:0] r;
        unique case (pos)
            5'd0, 5'd1: r = 4'd2;
            default:    r = 4'd4;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] v5_code(input logic [4:0] fp);
        logic [15:0] r;
        unique case (fp)
            5'd0:  r = 16'd8;
            5'd1:  r = 16'd12;
            5'd2:  r = 16'd15;
            5'd3:  r = 16'd10;
            5'd4:  r = 16'd14;
            5'd5:  r = 16'd2;
            5'd6:  r = 16'd1;
            5'd7:  r = 16'd22;
            5'd8:  r = 16'd21;
            5'd9:  r = 16'd7;
            5'd10: r = 16'd11;
            5'd12: r = 16'd6;
            5'd13: r = 16'd4;
            5'd14: r = 16'd5;
            5'd15: r = 16'd16;
            5'd16: r = 16'd17;
            5'd17: r = 16'd9;
            5'd18: r = 16'd13;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] v5_len(input logic [4:0] fp);
        logic [3:0] r;
        unique case (fp)
            5'd0, 5'd1, 5'd2, 5'd5, 5'd6, 5'd7, 5'd8: r = 4'd4;
            5'd11, 5'd12, 5'd13, 5'd14, 5'd17, 5'd18: r = 4'd1;
            default:                                  r = 4'd2;
        endcase
        return r;
    endfunction

endpackage

### src/nfd_front.sv
module nfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  nfd_pkg::t_in  i_word,
    output logic          o_valid,
    input  logic          i_take,
    output nfd_pkg::t_in  o_word
);
    import nfd_pkg::*;

    t_in        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_word;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### src/nfd_outq.sv
module nfd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_a,
    input  nfd_pkg::t_item  i_item_a,
    input  logic            i_push_b,
    input  nfd_pkg::t_item  i_item_b,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_stall,
    output nfd_pkg::t_item  o_item
);
    import nfd_pkg::*;

    t_item      r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    // two free entries: one decoded word plus a possible status word
    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[r_rp];
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push_a) begin
                r_q[r_wp] <= i_item_a;
            end
            if (i_push_b) begin
                r_q[r_wp + 2'(i_push_a)] <= i_item_b;
            end
            r_wp  <= r_wp + 2'(i_push_a) + 2'(i_push_b);
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push_a) + 3'(i_push_b) - 3'(w_pop);
        end
    end

endmodule

### src/nfd_parse.sv
module nfd_parse #(
    parameter int TEMPLATE_SLOTS = 16,
    parameter int MAX_FIELDS     = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_valid,
    input  nfd_pkg::t_in    i_word,
    input  logic            i_room,
    output logic            o_take,
    output logic            o_push_a,
    output nfd_pkg::t_item  o_item_a,
    output logic            o_push_b,
    output nfd_pkg::t_item  o_item_b
);
    import nfd_pkg::*;

    localparam int SW    = (TEMPLATE_SLOTS > 1) ? $clog2(TEMPLATE_SLOTS) : 1;
    localparam int PW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CW    = $clog2(MAX_FIELDS + 1);
    localparam int RLW   = 16 + PW;
    localparam int DEPTH = TEMPLATE_SLOTS << PW;
    localparam logic [15:0] MAXF = 16'(MAX_FIELDS);

    typedef enum logic [3:0] {
        PH_HDR, PH_V5REC, PH_SETHDR, PH_TPLHDR, PH_TPLFLD,
        PH_DATA, PH_PAD, PH_DONE, PH_DISCARD
    } t_phase;

    t_phase          r_phase,  n_phase;
    logic [2:0]      r_ubc,    n_ubc;
    logic            r_is5,    n_is5;
    logic            r_is9,    n_is9;
    logic [15:0]     r_sets,   n_sets;
    logic [15:0]     r_fsleft, n_fsleft;
    logic [15:0]     r_setid,  n_setid;
    logic [15:0]     r_fbl,    n_fbl;
    logic            r_fload,  n_fload;
    logic [15:0]     r_pos,    n_pos;
    logic [63:0]     r_shift,  n_shift;
    logic [15:0]     r_rec,    n_rec;
    logic [SW-1:0]   r_slot,   n_slot;
    logic            r_tseen,  n_tseen;
    logic [2:0]      r_status, n_status;
    logic [3:0]      r_cfill,  n_cfill;
    logic [4:0]      r_cidx,   n_cidx;
    logic [15:0]     r_tid,    n_tid;
    logic [15:0]     r_ttotal, n_ttotal;
    logic [15:0]     r_tcount, n_tcount;
    logic [RLW-1:0]  r_rlacc,  n_rlacc;
    logic            r_storing, n_storing;
    logic            r_keep;

    logic            r_svalid [TEMPLATE_SLOTS];
    logic [15:0]     r_sid    [TEMPLATE_SLOTS];
    logic [CW-1:0]   r_scount [TEMPLATE_SLOTS];
    logic [RLW-1:0]  r_srlen  [TEMPLATE_SLOTS];

    logic [31:0]     r_mem [DEPTH];
    logic [31:0]     r_rd_q;

    logic            w_fire;
    logic [15:0]     w_key;
    logic            w_hit;
    logic [SW-1:0]   w_hit_idx;
    logic            w_free;
    logic [SW-1:0]   w_free_idx;
    logic            w_clr_all;
    logic            w_hdr_wr;
    logic            w_set_valid;
    logic            w_mem_we;
    logic [31:0]     w_mem_wd;
    logic [SW+PW-1:0] w_mem_wa;
    logic [SW+PW-1:0] w_rd_addr;
    logic            w_trunc;

    assign w_fire = i_valid && i_room;
    assign o_take = w_fire;
    // id bytes of a four-byte header as they stand when its last byte arrives
    assign w_key  = r_shift[23:8];

    // parallel compare over the template table
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = TEMPLATE_SLOTS - 1; i >= 0; i--) begin
            if (r_svalid[i] && r_sid[i] == w_key) begin
                w_hit     = 1'b1;
                w_hit_idx = SW'(i);
            end
            if (!r_svalid[i]) begin
                w_free     = 1'b1;
                w_free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        logic [3:0]  flen;
        logic [4:0]  fp;
        logic [15:0] fbl;
        logic        fdone;
        logic        lastf;
        logic        tlast;
        logic        start;
        logic [15:0] tlen;

        n_phase   = r_phase;
        n_ubc     = r_ubc;
        n_is5     = r_is5;
        n_is9     = r_is9;
        n_sets    = r_sets;
        n_fsleft  = r_fsleft;
        n_setid   = r_setid;
        n_fbl     = r_fbl;
        n_fload   = r_fload;
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_rec     = r_rec;
        n_slot    = r_slot;
        n_tseen   = r_tseen;
        n_status  = r_status;
        n_cfill   = r_cfill;
        n_cidx    = r_cidx;
        n_tid     = r_tid;
        n_ttotal  = r_ttotal;
        n_tcount  = r_tcount;
        n_rlacc   = r_rlacc;
        n_storing = r_storing;
        w_clr_all   = 1'b0;
        w_hdr_wr    = 1'b0;
        w_set_valid = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_wd    = '0;
        w_mem_wa    = '0;
        o_push_a    = 1'b0;
        o_item_a    = '0;
        o_push_b    = 1'b0;
        o_item_b    = '0;
        w_trunc     = 1'b0;
        flen  = 4'd2;
        fp    = 5'd0;
        fbl   = 16'd0;
        fdone = 1'b0;
        lastf = 1'b0;
        tlast = 1'b0;
        start = 1'b0;
        tlen  = 16'd0;

        if (w_fire) begin
            unique case (r_phase)
                PH_HDR: begin
                    n_shift = {r_shift[55:0], i_word.data};
                    n_ubc   = r_ubc + 3'd1;
                    flen = r_is5 ? v5_hdr_len(r_pos[4:0]) :
                           r_is9 ? v9_hdr_len(r_pos[4:0]) : 4'd2;
                    if (4'(n_ubc) >= flen) begin
                        if (r_pos == 16'd0 && n_shift != VER_V5 && n_shift != VER_V9) begin
                            if (n_status == ST_OK) n_status = ST_BAD_VER;
                            n_phase = PH_DISCARD;
                        end else begin
                            if (r_pos == 16'd0) begin
                                n_is5 = (n_shift == VER_V5);
                                n_is9 = (n_shift == VER_V9);
                            end
                            o_push_a        = 1'b1;
                            o_item_a.kind   = KIND_HDR;
                            o_item_a.code   = r_pos;
                            o_item_a.value  = n_shift;
                            o_item_a.nbytes = flen;
                            if (r_pos == 16'd1) n_sets = n_shift[15:0];
                            n_pos   = r_pos + 16'd1;
                            n_ubc   = 3'd0;
                            n_shift = '0;
                            if (n_pos >= (n_is5 ? 16'd9 : 16'd6)) begin
                                n_pos = 16'd0;
                                if (n_is5) begin
                                    n_phase = (n_sets != 16'd0) ? PH_V5REC : PH_DONE;
                                    n_fbl   = 16'(v5_len(5'd0));
                                    n_fload = 1'b0;
                                end else begin
                                    n_phase = (n_sets != 16'd0) ? PH_SETHDR : PH_DONE;
                                end
                            end
                        end
                    end
                end
                PH_V5REC: begin
                    fp = r_pos[4:0];
                    n_shift = {r_shift[55:0], i_word.data};
                    if (r_fbl != 16'd0) n_fbl = r_fbl - 16'd1;
                    if (n_fbl == 16'd0) begin
                        o_push_a         = 1'b1;
                        o_item_a.kind    = KIND_FLOW;
                        o_item_a.code    = v5_code(fp);
                        o_item_a.rec_num = r_rec;
                        o_item_a.value   = n_shift;
                        o_item_a.nbytes  = v5_len(fp);
                        o_item_a.done    = (fp == V5_FIELDS - 5'd1);
                        n_shift = '0;
                        fp = fp + 5'd1;
                        if (fp == V5_FIELDS) begin
                            fp    = 5'd0;
                            n_rec = r_rec + 16'd1;
                            if (n_sets != 16'd0) n_sets = n_sets - 16'd1;
                            if (n_sets == 16'd0) n_phase = PH_DONE;
                        end
                        n_pos = 16'(fp);
                        n_fbl = 16'(v5_len(fp));
                    end
                end
                PH_SETHDR: begin
                    n_shift = {r_shift[55:0], i_word.data};
                    n_ubc   = r_ubc + 3'd1;
                    if (n_ubc == 3'd4) begin
                        n_setid  = n_shift[31:16];
                        n_fsleft = (n_shift[15:0] >= 16'd4) ? n_shift[15:0] - 16'd4 : 16'd0;
                        if (n_sets != 16'd0) n_sets = n_sets - 16'd1;
                        n_ubc   = 3'd0;
                        if (n_setid <= TPL_ID_MAX) begin
                            if (r_keep && !r_tseen) w_clr_all = 1'b1;
                            n_tseen = 1'b1;
                            n_phase = PH_TPLHDR;
                        end else if (r_keep && w_hit) begin
                            n_slot = w_hit_idx;
                            start  = 1'b1;
                        end else begin
                            n_phase = PH_PAD;
                        end
                        n_shift = '0;
                    end
                end
                PH_TPLHDR, PH_TPLFLD, PH_DATA, PH_PAD: begin
                    if (r_fsleft != 16'd0) n_fsleft = r_fsleft - 16'd1;
                    if (r_phase == PH_TPLHDR) begin
                        n_shift = {r_shift[55:0], i_word.data};
                        n_ubc   = r_ubc + 3'd1;
                        if (n_ubc == 3'd4) begin
                            n_tid     = n_shift[31:16];
                            n_ttotal  = n_shift[15:0];
                            n_ubc     = 3'd0;
                            n_shift   = '0;
                            n_pos     = 16'd0;
                            n_rlacc   = '0;
                            n_storing = 1'b0;
                            if (n_ttotal == 16'd0 || n_ttotal > MAXF) begin
                                if (n_status == ST_OK) n_status = ST_BAD_TPL;
                            end else if (r_keep) begin
                                if (!w_hit && !w_free) begin
                                    if (n_status == ST_OK) n_status = ST_FULL;
                                end else begin
                                    n_slot    = w_hit ? w_hit_idx : w_free_idx;
                                    w_hdr_wr  = 1'b1;
                                    n_storing = 1'b1;
                                end
                            end
                            if (n_ttotal == 16'd0) n_tcount = r_tcount + 16'd1;
                            else n_phase = PH_TPLFLD;
                        end
                    end else if (r_phase == PH_TPLFLD) begin
                        n_shift = {r_shift[55:0], i_word.data};
                        n_ubc   = r_ubc + 3'd1;
                        if (n_ubc == 3'd4) begin
                            tlen  = n_shift[15:0];
                            tlast = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_ttotal};
                            o_push_a         = 1'b1;
                            o_item_a.kind    = KIND_TPL;
                            o_item_a.code    = n_shift[31:16];
                            o_item_a.set_num = r_tid;
                            o_item_a.rec_num = r_tcount;
                            o_item_a.value   = 64'(tlen);
                            o_item_a.nbytes  = 4'd2;
                            o_item_a.done    = tlast;
                            if (tlen == 16'd0) begin
                                if (n_status == ST_OK) n_status = ST_BAD_TPL;
                                n_storing = 1'b0;
                            end
                            if (n_storing) begin
                                w_mem_we = 1'b1;
                                w_mem_wa = {r_slot, r_pos[PW-1:0]};
                                w_mem_wd = n_shift[31:0];
                                n_rlacc  = r_rlacc + RLW'(tlen);
                            end
                            n_pos   = r_pos + 16'd1;
                            n_ubc   = 3'd0;
                            n_shift = '0;
                            if (tlast) begin
                                if (n_storing) w_set_valid = 1'b1;
                                n_storing = 1'b0;
                                n_tcount  = r_tcount + 16'd1;
                                n_phase   = PH_TPLHDR;
                            end
                        end
                    end else if (r_phase == PH_DATA) begin
                        n_shift = {r_shift[55:0], i_word.data};
                        n_cfill = r_cfill + 4'd1;
                        fbl = r_fload ? r_rd_q[15:0] : r_fbl;
                        if (fbl != 16'd0) fbl = fbl - 16'd1;
                        n_fbl   = fbl;
                        n_fload = 1'b0;
                        fdone = (fbl == 16'd0);
                        lastf = ({1'b0, r_pos} + 17'd1) >= 17'(r_scount[r_slot]);
                        if (fdone || n_cfill >= 4'd8) begin
                            o_push_a         = 1'b1;
                            o_item_a.kind    = KIND_FLOW;
                            o_item_a.code    = r_rd_q[31:16];
                            o_item_a.set_num = r_setid;
                            o_item_a.rec_num = r_rec;
                            o_item_a.chunk   = r_cidx;
                            o_item_a.value   = n_shift;
                            o_item_a.nbytes  = n_cfill;
                            o_item_a.done    = fdone && lastf;
                            n_shift = '0;
                            n_cfill = 4'd0;
                            n_cidx  = r_cidx + 5'd1;
                        end
                        if (fdone) begin
                            n_cidx = 5'd0;
                            if (lastf) begin
                                n_rec = r_rec + 16'd1;
                                start = 1'b1;
                            end else begin
                                n_pos   = r_pos + 16'd1;
                                n_fload = 1'b1;
                            end
                        end
                    end
                    if (n_fsleft == 16'd0 && n_phase == PH_TPLFLD) begin
                        if (n_status == ST_OK) n_status = ST_BAD_TPL;
                        n_storing = 1'b0;
                    end
                end
                PH_DONE, PH_DISCARD: begin
                end
                default: begin
                end
            endcase

            // a record starts only if all of it fits in the flowset
            if (start) begin
                if (n_fsleft != 16'd0 && RLW'(n_fsleft) >= r_srlen[n_slot]) begin
                    n_phase = PH_DATA;
                    n_pos   = 16'd0;
                    n_fload = 1'b1;
                    n_cfill = 4'd0;
                    n_cidx  = 5'd0;
                    n_shift = '0;
                end else begin
                    n_phase = PH_PAD;
                end
            end

            if ((r_phase == PH_SETHDR && n_ubc == 3'd0) || r_phase == PH_TPLHDR ||
                r_phase == PH_TPLFLD || r_phase == PH_DATA || r_phase == PH_PAD) begin
                if (n_fsleft == 16'd0) begin
                    n_phase = (n_sets != 16'd0) ? PH_SETHDR : PH_DONE;
                    n_ubc   = 3'd0;
                    n_shift = '0;
                end
            end

            if (i_word.last) begin
                w_trunc = n_phase == PH_HDR || n_phase == PH_V5REC || n_phase == PH_TPLHDR ||
                          n_phase == PH_TPLFLD || n_phase == PH_DATA || n_phase == PH_PAD ||
                          (n_phase == PH_SETHDR && n_ubc != 3'd0);
                o_push_b        = 1'b1;
                o_item_b.kind   = KIND_STATUS;
                o_item_b.nbytes = 4'd1;
                o_item_b.status = w_trunc ? ST_TRUNC : n_status;
                n_phase   = PH_HDR;
                n_ubc     = 3'd0;
                n_is5     = 1'b0;
                n_is9     = 1'b0;
                n_sets    = 16'd0;
                n_fsleft  = 16'd0;
                n_setid   = 16'd0;
                n_fbl     = 16'd0;
                n_fload   = 1'b0;
                n_pos     = 16'd0;
                n_shift   = '0;
                n_rec     = 16'd0;
                n_tseen   = 1'b0;
                n_status  = ST_OK;
                n_cfill   = 4'd0;
                n_cidx    = 5'd0;
                n_tid     = 16'd0;
                n_ttotal  = 16'd0;
                n_tcount  = 16'd0;
                n_rlacc   = '0;
                n_storing = 1'b0;
            end
        end
    end

    // read ahead from the next slot and position so the entry of the current field is ready
    assign w_rd_addr = {n_slot, n_pos[PW-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_rd_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TEMPLATE_SLOTS; i++) begin
                r_svalid[i] <= 1'b0;
            end
        end else begin
            if (w_clr_all) begin
                for (int i = 0; i < TEMPLATE_SLOTS; i++) begin
                    r_svalid[i] <= 1'b0;
                end
            end
            if (w_hdr_wr) begin
                r_svalid[n_slot] <= 1'b0;
                r_sid[n_slot]    <= n_tid;
                r_scount[n_slot] <= CW'(n_ttotal);
            end
            if (w_set_valid) begin
                r_svalid[r_slot] <= 1'b1;
                r_srlen[r_slot]  <= n_rlacc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_ubc     <= 3'd0;
            r_is5     <= 1'b0;
            r_is9     <= 1'b0;
            r_sets    <= 16'd0;
            r_fsleft  <= 16'd0;
            r_setid   <= 16'd0;
            r_fbl     <= 16'd0;
            r_fload   <= 1'b0;
            r_pos     <= 16'd0;
            r_shift   <= '0;
            r_rec     <= 16'd0;
            r_slot    <= '0;
            r_tseen   <= 1'b0;
            r_status  <= ST_OK;
            r_cfill   <= 4'd0;
            r_cidx    <= 5'd0;
            r_tid     <= 16'd0;
            r_ttotal  <= 16'd0;
            r_tcount  <= 16'd0;
            r_rlacc   <= '0;
            r_storing <= 1'b0;
            r_keep    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ubc     <= n_ubc;
            r_is5     <= n_is5;
            r_is9     <= n_is9;
            r_sets    <= n_sets;
            r_fsleft  <= n_fsleft;
            r_setid   <= n_setid;
            r_fbl     <= n_fbl;
            r_fload   <= n_fload;
            r_pos     <= n_pos;
            r_shift   <= n_shift;
            r_rec     <= n_rec;
            r_slot    <= n_slot;
            r_tseen   <= n_tseen;
            r_status  <= n_status;
            r_cfill   <= n_cfill;
            r_cidx    <= n_cidx;
            r_tid     <= n_tid;
            r_ttotal  <= n_ttotal;
            r_tcount  <= n_tcount;
            r_rlacc   <= n_rlacc;
            r_storing <= n_storing;
            if (i_cfg_we) begin
                r_keep <= i_cfg_wdata;
            end
        end
    end

endmodule

### src/netflow_v5_v9_packet_decoder.sv
// channel   direction  handshake           word
// input     in         i_valid / o_stall   i_payload_byte, i_packet_end
// output    out        o_valid / i_stall   o_item_kind .. o_status_code
// config    in         i_cfg_we            i_cfg_wdata (keep_templates)
//
// one payload byte per cycle; the parser takes a byte from the input queue
// whenever the output queue has two free entries (a byte yields at most one
// decoded word plus a status word on the last byte of a packet)
// template table is read ahead through a registered memory port
// a byte passes through the input and output queue registers; reset clears
// the template valid bits at once, with no clearing pass
module netflow_v5_v9_packet_decoder #(
    parameter int TEMPLATE_SLOTS = 16,
    parameter int MAX_FIELDS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_packet_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_field_code,
    output logic [15:0] o_set_number,
    output logic [15:0] o_record_number,
    output logic [4:0]  o_chunk_number,
    output logic [63:0] o_field_value,
    output logic [3:0]  o_value_bytes,
    output logic        o_record_done,
    output logic [2:0]  o_status_code
);
    import nfd_pkg::*;

    t_in   w_in_word;
    t_in   w_q_word;
    logic  w_q_valid;
    logic  w_take;
    logic  w_room;
    logic  w_push_a;
    logic  w_push_b;
    t_item w_item_a;
    t_item w_item_b;
    t_item w_out;

    assign w_in_word.data = i_payload_byte;
    assign w_in_word.last = i_packet_end;

    nfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (w_in_word),
        .o_valid (w_q_valid),
        .i_take  (w_take),
        .o_word  (w_q_word)
    );

    nfd_parse #(
        .TEMPLATE_SLOTS (TEMPLATE_SLOTS),
        .MAX_FIELDS     (MAX_FIELDS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_q_valid),
        .i_word      (w_q_word),
        .i_room      (w_room),
        .o_take      (w_take),
        .o_push_a    (w_push_a),
        .o_item_a    (w_item_a),
        .o_push_b    (w_push_b),
        .o_item_b    (w_item_b)
    );

    nfd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (w_push_a),
        .i_item_a (w_item_a),
        .i_push_b (w_push_b),
        .i_item_b (w_item_b),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (w_out)
    );

    assign o_item_kind     = w_out.kind;
    assign o_field_code    = w_out.code;
    assign o_set_number    = w_out.set_num;
    assign o_record_number = w_out.rec_num;
    assign o_chunk_number  = w_out.chunk;
    assign o_field_value   = w_out.value;
    assign o_value_bytes   = w_out.nbytes;
    assign o_record_done   = w_out.done;
    assign o_status_code   = w_out.status;

`ifndef ASSERT_OFF
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_STATUS) |->
            (o_value_bytes == 4'd1 && o_field_value == 64'd0 && !o_record_done))
        else $error("status word malformed");

    a_code_only_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind != KIND_STATUS) |-> (o_status_code == ST_OK))
        else $error("status code on a data word");

    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value_bytes != 4'd0 && o_value_bytes <= 4'd8))
        else $error("value byte count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_a || w_push_b) |-> $past(w_room) || w_room)
        else $error("result pushed without queue room");
`endif

endmodule

### test/netflow_v5_v9_packet_decoder_tb.sv
`timescale 1ns / 100ps

module netflow_v5_v9_packet_decoder_tb;
    import nfd_pkg::*;

    localparam int SLOTS       = 16;
    localparam int FIELDS_MAX  = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum int {
        PH_HEADER, PH_V5_RECORD, PH_SET_HEADER, PH_TPL_HEADER, PH_TPL_FIELD,
        PH_DATA_REC, PH_PADDING, PH_FINISHED, PH_DROP
    } t_parse;

    class t_flow_scoreboard;
        bit          keep;
        t_parse      ph;
        int unsigned ubc, ver, fs_left, fbl, fpos, cfill, cidx, ttot, rlen;
        bit [15:0]   sets_left, set_id, rec_cnt, tid, tcnt;
        bit [63:0]   shift;
        bit [2:0]    first_err;
        int unsigned act_slot;
        bit          tpl_seen, storing;
        bit          sv[SLOTS];
        bit [15:0]   sid[SLOTS];
        int unsigned scnt[SLOTS], srlen[SLOTS];
        bit [31:0]   sent[SLOTS][FIELDS_MAX];
        t_item       items_due[$];
        int          errors;
        int unsigned v5h[9]  = '{2, 2, 4, 4, 4, 4, 1, 1, 2};
        int unsigned v9h[6]  = '{2, 2, 4, 4, 4, 4};
        int unsigned v5c[20] = '{8, 12, 15, 10, 14, 2, 1, 22, 21, 7, 11, 0, 6, 4, 5, 16,
                                 17, 9, 13, 0};
        int unsigned v5l[20] = '{4, 4, 4, 2, 2, 4, 4, 4, 4, 2, 2, 1, 1, 1, 1, 2, 2, 1, 1, 2};

        function new();
            keep = 0;
            act_slot = 0;
            errors = 0;
            foreach (sv[i]) begin
                sv[i] = 0; sid[i] = 0; scnt[i] = 0; srlen[i] = 0;
                foreach (sent[i][j]) sent[i][j] = 0;
            end
            packet_clear();
        endfunction

        function void packet_clear();
            ph = PH_HEADER; ubc = 0; ver = 0; sets_left = 0; fs_left = 0; set_id = 0;
            fbl = 0; fpos = 0; shift = 0; rec_cnt = 0; tpl_seen = 0; first_err = ST_OK;
            cfill = 0; cidx = 0; tid = 0; ttot = 0; tcnt = 0; rlen = 0; storing = 0;
        endfunction

        function void add(bit [1:0] kind, bit [15:0] code, bit [15:0] set_n, bit [15:0] rec,
                          bit [4:0] chunk, bit [63:0] val, bit [3:0] nb, bit done,
                          bit [2:0] st);
            t_item t;
            t.kind = kind; t.code = code; t.set_num = set_n; t.rec_num = rec;
            t.chunk = chunk; t.value = val; t.nbytes = nb; t.done = done; t.status = st;
            items_due.push_back(t);
        endfunction

        function void hold_err(bit [2:0] c);
            if (first_err == ST_OK) first_err = c;
        endfunction

        function bit [31:0] entry(int unsigned s, int unsigned i);
            if (s >= SLOTS || i >= FIELDS_MAX) return 0;
            return sent[s][i];
        endfunction

        function void close_set();
            ph = (sets_left != 0) ? PH_SET_HEADER : PH_FINISHED;
            ubc = 0;
            shift = 0;
        endfunction

        function int find_slot(bit [15:0] id, bit allow_free);
            for (int i = 0; i < SLOTS; i++) if (sv[i] && sid[i] == id) return i;
            if (allow_free) for (int i = 0; i < SLOTS; i++) if (!sv[i]) return i;
            return -1;
        endfunction

        // a record starts only when all of it fits before the flowset end
        function void open_record();
            if (fs_left > 0 && fs_left >= srlen[act_slot]) begin
                ph = PH_DATA_REC;
                fpos = 0;
                fbl = entry(act_slot, 0) & 32'hFFFF;
                cfill = 0; cidx = 0; shift = 0;
            end else begin
                ph = PH_PADDING;
            end
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            int unsigned flen, cnt, len;
            bit [15:0]   id, ftype;
            int          s;
            bit          fdone, lastf, is_last, trunc;
            bit [31:0]   e;
            case (ph)
                PH_HEADER: begin
                    shift = (shift << 8) | b;
                    ubc++;
                    flen = (ver == 5) ? v5h[fpos % 9] : (ver == 9) ? v9h[fpos % 6] : 2;
                    if (ubc >= flen) begin
                        if (fpos == 0) begin
                            if (shift == VER_V5) ver = 5;
                            else if (shift == VER_V9) ver = 9;
                            else begin hold_err(ST_BAD_VER); ph = PH_DROP; end
                        end
                        if (ph != PH_DROP) begin
                            add(KIND_HDR, fpos, 0, 0, 0, shift, flen, 0, ST_OK);
                            if (fpos == 1) sets_left = shift[15:0];
                            fpos++;
                            ubc = 0;
                            shift = 0;
                            cnt = (ver == 5) ? 9 : 6;
                            if (fpos >= cnt) begin
                                fpos = 0;
                                if (ver == 5) begin
                                    ph = (sets_left != 0) ? PH_V5_RECORD : PH_FINISHED;
                                    fbl = v5l[0];
                                end else begin
                                    ph = (sets_left != 0) ? PH_SET_HEADER : PH_FINISHED;
                                end
                            end
                        end
                    end
                end
                PH_V5_RECORD: begin
                    fpos = fpos % 20;
                    shift = (shift << 8) | b;
                    if (fbl != 0) fbl--;
                    if (fbl == 0) begin
                        add(KIND_FLOW, v5c[fpos], 0, rec_cnt, 0, shift, v5l[fpos],
                            fpos == 19, ST_OK);
                        shift = 0;
                        fpos++;
                        if (fpos == 20) begin
                            fpos = 0;
                            rec_cnt++;
                            if (sets_left != 0) sets_left--;
                            if (sets_left == 0) ph = PH_FINISHED;
                        end
                        fbl = v5l[fpos];
                    end
                end
                PH_SET_HEADER: begin
                    shift = (shift << 8) | b;
                    ubc++;
                    if (ubc >= 4) begin
                        id = shift[31:16];
                        len = shift[15:0];
                        set_id = id;
                        fs_left = (len >= 4) ? len - 4 : 0;
                        if (sets_left != 0) sets_left--;
                        ubc = 0;
                        shift = 0;
                        if (id <= TPL_ID_MAX) begin
                            // with keep set, the first template flowset of a packet wipes the table
                            if (keep && !tpl_seen) foreach (sv[i]) sv[i] = 0;
                            tpl_seen = 1;
                            ph = PH_TPL_HEADER;
                        end else begin
                            s = keep ? find_slot(id, 0) : -1;
                            if (s >= 0) begin act_slot = s; open_record(); end
                            else ph = PH_PADDING;
                        end
                        if (fs_left == 0) close_set();
                    end
                end
                PH_TPL_HEADER, PH_TPL_FIELD, PH_DATA_REC, PH_PADDING: begin
                    if (fs_left != 0) fs_left--;
                    if (ph == PH_TPL_HEADER) begin
                        shift = (shift << 8) | b;
                        ubc++;
                        if (ubc == 4) begin
                            tid = shift[31:16];
                            ttot = shift[15:0];
                            ubc = 0; shift = 0; fpos = 0; rlen = 0; storing = 0;
                            if (ttot == 0 || ttot > FIELDS_MAX) begin
                                hold_err(ST_BAD_TPL);
                            end else if (keep) begin
                                s = find_slot(tid, 1);
                                if (s < 0) hold_err(ST_FULL);
                                else begin
                                    act_slot = s;
                                    sv[s] = 0;
                                    sid[s] = tid;
                                    scnt[s] = ttot;
                                    storing = 1;
                                end
                            end
                            if (ttot == 0) tcnt++;
                            else ph = PH_TPL_FIELD;
                        end
                    end else if (ph == PH_TPL_FIELD) begin
                        shift = (shift << 8) | b;
                        ubc++;
                        if (ubc == 4) begin
                            ftype = shift[31:16];
                            flen = shift[15:0];
                            is_last = fpos + 1 >= ttot;
                            add(KIND_TPL, ftype, tid, tcnt, 0, flen, 2, is_last, ST_OK);
                            if (flen == 0) begin hold_err(ST_BAD_TPL); storing = 0; end
                            if (storing && fpos < FIELDS_MAX && act_slot < SLOTS) begin
                                sent[act_slot][fpos] = {ftype, flen[15:0]};
                                rlen += flen;
                            end
                            fpos++;
                            ubc = 0;
                            shift = 0;
                            if (is_last) begin
                                if (storing) begin
                                    sv[act_slot] = 1;
                                    srlen[act_slot] = rlen;
                                end
                                storing = 0;
                                tcnt++;
                                ph = PH_TPL_HEADER;
                            end
                        end
                    end else if (ph == PH_DATA_REC) begin
                        e = entry(act_slot, fpos);
                        shift = (shift << 8) | b;
                        cfill++;
                        if (fbl != 0) fbl--;
                        fdone = fbl == 0;
                        lastf = fpos + 1 >= scnt[act_slot];
                        if (fdone || cfill >= 8) begin
                            add(KIND_FLOW, e[31:16], set_id, rec_cnt, cidx[4:0], shift, cfill,
                                fdone && lastf, ST_OK);
                            shift = 0;
                            cfill = 0;
                            cidx = (cidx + 1) & 31;
                        end
                        if (fdone) begin
                            cidx = 0;
                            if (lastf) begin
                                rec_cnt++;
                                open_record();
                            end else begin
                                fpos++;
                                fbl = entry(act_slot, fpos) & 32'hFFFF;
                            end
                        end
                    end
                    if (fs_left == 0) begin
                        if (ph == PH_TPL_FIELD) begin hold_err(ST_BAD_TPL); storing = 0; end
                        close_set();
                    end
                end
                default: ;
            endcase
            if (last) begin
                trunc = ph inside {PH_HEADER, PH_V5_RECORD, PH_TPL_HEADER, PH_TPL_FIELD,
                                   PH_DATA_REC, PH_PADDING} ||
                        (ph == PH_SET_HEADER && ubc > 0);
                add(KIND_STATUS, 0, 0, 0, 0, 0, 1, 0, trunc ? ST_TRUNC : first_err);
                packet_clear();
            end
        endfunction

        task report(string what, t_item got, t_item want);
            errors++;
            if (errors <= 20) $display("mismatch %s: got %p want %p", what, got, want);
        endtask

        task check_word(t_item got);
            t_item want;
            if (items_due.size() == 0) begin
                report("unexpected word", got, got);
                return;
            end
            want = items_due.pop_front();
            if (got.kind != want.kind || got.code != want.code || got.set_num != want.set_num ||
                got.rec_num != want.rec_num || got.chunk != want.chunk ||
                got.value != want.value || got.nbytes != want.nbytes ||
                got.done != want.done || got.status != want.status)
                report("field", got, want);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_wdata = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_payload_byte = 0;
    logic        i_packet_end = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_item_kind;
    logic [15:0] o_field_code;
    logic [15:0] o_set_number;
    logic [15:0] o_record_number;
    logic [4:0]  o_chunk_number;
    logic [63:0] o_field_value;
    logic [3:0]  o_value_bytes;
    logic        o_record_done;
    logic [2:0]  o_status_code;

    t_flow_scoreboard sb = new();
    bit [7:0]       pkt[$];
    bit [15:0]      known_ids[$];
    int unsigned    known_len[int];
    bit             steady = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    out_hold = 0;
    int unsigned    idle_cycles = 0;

    netflow_v5_v9_packet_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_payload_byte(i_payload_byte),
        .i_packet_end(i_packet_end), .o_valid(o_valid), .i_stall(i_stall),
        .o_item_kind(o_item_kind), .o_field_code(o_field_code), .o_set_number(o_set_number),
        .o_record_number(o_record_number), .o_chunk_number(o_chunk_number),
        .o_field_value(o_field_value), .o_value_bytes(o_value_bytes),
        .o_record_done(o_record_done), .o_status_code(o_status_code)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned draw_wait();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    function automatic void put_bytes(bit [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) pkt.push_back(v[8*i +: 8]);
    endfunction

    // result side: sample each word, then draw a new stall
    always @(posedge i_clk) begin
        t_item got;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.kind = o_item_kind; got.code = o_field_code; got.set_num = o_set_number;
                got.rec_num = o_record_number; got.chunk = o_chunk_number;
                got.value = o_field_value; got.nbytes = o_value_bytes;
                got.done = o_record_done; got.status = o_status_code;
                sb.check_word(got);
                out_hold = steady ? 0 : draw_wait();
            end else if (out_hold > 0) begin
                out_hold--;
            end
            i_stall <= (out_hold != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(bit [7:0] b, bit last);
        int unsigned gap;
        gap = steady ? 0 : draw_wait();
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_payload_byte <= b;
        i_packet_end <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        steady = ($urandom_range(0, 3) == 0);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.items_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_keep(bit v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.keep = v;
        i_cfg_we <= 0;
    endtask

    task automatic build_v5();
        int unsigned n;
        pkt.delete();
        n = $urandom_range(0, 2);
        put_bytes(VER_V5, 2);
        put_bytes(64'((($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : n)), 2);
        repeat (4) put_bytes(64'($urandom), 4);
        put_bytes(64'($urandom), 1);
        put_bytes(64'($urandom), 1);
        put_bytes(64'($urandom), 2);
        repeat (n * 48) pkt.push_back(8'($urandom));
    endtask

    task automatic build_v9();
        int unsigned nsets, nfld, flen, rlen, nrec, len;
        bit [15:0]   id, tpl;
        bit [7:0]    fs[$];
        pkt.delete();
        nsets = $urandom_range(1, 4);
        put_bytes(VER_V9, 2);
        put_bytes(64'((($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : nsets)), 2);
        repeat (4) put_bytes(64'($urandom), 4);
        for (int s = 0; s < nsets; s++) begin
            fs.delete();
            if (s == 0 || known_ids.size() == 0 || $urandom_range(0, 2) == 0) begin
                id = 16'($urandom_range(0, 255));
                repeat ($urandom_range(1, 2)) begin
                    // ids from a pool a bit larger than the table so it can fill up
                    tpl = 16'(256 + $urandom_range(0, 19));
                    case ($urandom_range(0, 15))
                        0: nfld = 0;
                        1: nfld = FIELDS_MAX + 1;
                        default: nfld = $urandom_range(1, 3);
                    endcase
                    fs.push_back(tpl[15:8]); fs.push_back(tpl[7:0]);
                    fs.push_back(nfld[15:8]); fs.push_back(nfld[7:0]);
                    rlen = 0;
                    for (int f = 0; f < nfld && f < 3; f++) begin
                        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                           : $urandom_range(1, 6);
                        repeat (2) fs.push_back(8'($urandom));
                        fs.push_back(flen[15:8]); fs.push_back(flen[7:0]);
                        rlen += flen;
                    end
                    if (nfld >= 1 && nfld <= 3) begin
                        if (!known_len.exists(tpl)) known_ids.push_back(tpl);
                        known_len[tpl] = rlen;
                    end
                end
            end else begin
                id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                if ($urandom_range(0, 7) == 0) id = 16'(300 + $urandom_range(0, 65000));
                rlen = known_len.exists(id) ? known_len[id] : 4;
                nrec = $urandom_range(1, 2);
                repeat (nrec * rlen) fs.push_back(8'($urandom));
            end
            repeat ($urandom_range(0, 3)) fs.push_back(8'd0);
            len = fs.size() + 4;
            if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 3);
            put_bytes(64'(id), 2);
            put_bytes(64'(len), 2);
            foreach (fs[i]) pkt.push_back(fs[i]);
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
        end
    endtask

    initial begin
        int unsigned target;
        bit          keep_plan[4] = '{1, 0, 1, 0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        write_keep(0);

        // directed: bad version, one-byte packet, v9 header with no sets at full values
        pkt = '{8'hFF, 8'hFF};
        send_packet();
        pkt = '{8'h00};
        send_packet();
        pkt.delete();
        put_bytes(VER_V9, 2);
        put_bytes(64'd0, 2);
        repeat (4) put_bytes(64'h0000_0000_FFFF_FFFF, 4);
        send_packet();

        foreach (keep_plan[p]) begin
            write_keep(keep_plan[p]);
            target = bytes_sent + 100;
            while (bytes_sent < target) begin
                case ($urandom_range(0, 9))
                    0: begin
                        pkt.delete();
                        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
                    end
                    1, 2: build_v5();
                    default: build_v9();
                endcase
                if ($urandom_range(0, 7) == 0) pkt = pkt[0 : $urandom_range(0, pkt.size() - 1)];
                send_packet();
            end
        end

        drain();
        if (sb.items_due.size() != 0) sb.report("missing words", '0, sb.items_due[0]);
        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
src/nfd_pkg.sv
src/nfd_front.sv
src/nfd_outq.sv
src/nfd_parse.sv
src/netflow_v5_v9_packet_decoder.sv
test/netflow_v5_v9_packet_decoder_tb.sv
